// ===== rtl/ulm_pkg.sv =====
// Shared types, constants and decode helpers for the UTF-8 length-limit measure block.
package ulm_pkg;

  localparam logic [1:0] MODE_BYTES = 2'd0;
  localparam logic [1:0] MODE_CHARS = 2'd1;
  localparam logic [1:0] MODE_WIDTH = 2'd2;

  localparam logic [7:0]  LEAD1_MASK  = 8'h80;
  localparam logic [7:0]  LEAD2_MASK  = 8'hE0;
  localparam logic [7:0]  LEAD2_VAL   = 8'hC0;
  localparam logic [7:0]  LEAD3_MASK  = 8'hF0;
  localparam logic [7:0]  LEAD3_VAL   = 8'hE0;
  localparam logic [20:0] ZW_FIRST    = 21'h0200B;
  localparam logic [20:0] ZW_LAST     = 21'h0200D;
  localparam logic [20:0] BOM_CP      = 21'h0FEFF;
  localparam logic [20:0] ASCII_LIMIT = 21'h00080;

  typedef struct packed {
    logic [7:0]  text_byte;
    logic        last_byte;
    logic [15:0] remove_start;
    logic [15:0] remove_end;
    logic [15:0] keep_budget;
  } in_item_t;

  typedef struct packed {
    logic [15:0] measured_length;
    logic [15:0] cut_index;
    logic        over_budget;
    logic [15:0] utf16_units;
  } out_item_t;

  // One finished character, as seen by the accumulators.
  typedef struct packed {
    logic       fin;
    logic [2:0] received;
    logic [2:0] measure;
    logic [1:0] units;
  } char_info_t;

  function automatic logic [2:0] lead_length(input logic [7:0] c);
    logic [2:0] len;
    if ((c & LEAD1_MASK) == 8'h00) len = 3'd1;
    else if ((c & LEAD2_MASK) == LEAD2_VAL) len = 3'd2;
    else if ((c & LEAD3_MASK) == LEAD3_VAL) len = 3'd3;
    else len = 3'd4;
    return len;
  endfunction

  function automatic logic [1:0] cp_columns(input logic [20:0] cp);
    logic [1:0] w;
    if (cp < ASCII_LIMIT) w = 2'd1;
    else if (cp >= ZW_FIRST && cp <= ZW_LAST) w = 2'd1;
    else if (cp == BOM_CP) w = 2'd1;
    else w = 2'd2;
    return w;
  endfunction

endpackage

// ===== rtl/utf8_length_limit_measure.sv =====
// Top level of the UTF-8 length-limit measure block: input register, decoder, counters.
// Throughput: one byte per cycle; the input register decodes and counts in a single pass,
//   limited by the prefix compare and saturating adders feeding the result register.
// A result waiting on out_stall blocks only a following last byte; other bytes keep flowing.
// Reset (rst_n low, synchronous) clears all string counters, the decoder and limit_mode.
module utf8_length_limit_measure #(
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ulm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ulm_pkg::out_item_t out_item,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data
);
  import ulm_pkg::*;

  // Input register: holds one byte item until the counters take it.
  in_item_t   in_item_r;
  logic       in_valid_r;
  logic [1:0] limit_mode_r;
  logic       advance;
  char_info_t info;

  // Advance the held byte unless it closes a string and the result slot is still occupied.
  assign advance  = in_valid_r && (!in_item_r.last_byte || !out_valid || !out_stall);
  assign in_stall = in_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      limit_mode_r <= MODE_BYTES;
    end else begin
      if (in_valid && !in_stall) in_valid_r <= 1'b1;
      else if (advance) in_valid_r <= 1'b0;
      // The user must change the mode only while the block is idle; the block itself does not enforce this.
      if (cfg_wr_en) limit_mode_r <= cfg_wr_data;
    end
  end

  // Payload needs no reset; capture on every accepted item.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_item_r <= in_item;
  end

  // Decode the held byte and tell the counters when a character closes.
  ulm_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .text_byte  (in_item_r.text_byte),
    .last_byte  (in_item_r.last_byte),
    .limit_mode (limit_mode_r),
    .info       (info)
  );

  // Accumulate measures, search the cut point and register the result on the last byte.
  ulm_accum #(
    .COUNT_BITS (COUNT_BITS)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (in_item_r),
    .info      (info),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ===== rtl/ulm_decode.sv =====
// Byte-level UTF-8 character decoder: tracks the open character and reports its measure.
module ulm_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          text_byte,
  input  logic                last_byte,
  input  logic [1:0]          limit_mode,
  output ulm_pkg::char_info_t info
);
  import ulm_pkg::*;

  logic [2:0]  left_r, left_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic        truncated;
  logic [1:0]  width;

  always_comb begin
    if (left_r == 3'd0) begin
      len_nxt  = lead_length(text_byte);
      left_nxt = len_nxt - 3'd1;
      unique case (len_nxt)
        3'd1:    acc_nxt = {14'd0, text_byte[6:0]};
        3'd2:    acc_nxt = {16'd0, text_byte[4:0]};
        3'd3:    acc_nxt = {17'd0, text_byte[3:0]};
        default: acc_nxt = {18'd0, text_byte[2:0]};
      endcase
    end else begin
      len_nxt  = len_r;
      left_nxt = left_r - 3'd1;
      acc_nxt  = {acc_r[14:0], text_byte[5:0]};
    end
    truncated     = left_nxt != 3'd0;
    width         = truncated ? 2'd2 : cp_columns(acc_nxt);
    info.fin      = !truncated || last_byte;
    info.received = len_nxt - left_nxt;
    info.units    = (len_nxt == 3'd4) ? 2'd2 : 2'd1;
    unique case (limit_mode)
      MODE_BYTES: info.measure = info.received;
      MODE_CHARS: info.measure = 3'd1;
      MODE_WIDTH: info.measure = {1'b0, width};
      default:    info.measure = 3'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= 3'd0;
      len_r  <= 3'd0;
      acc_r  <= 21'd0;
    end else if (step) begin
      if (info.fin) begin
        left_r <= 3'd0;
        len_r  <= 3'd0;
        acc_r  <= 21'd0;
      end else begin
        left_r <= left_nxt;
        len_r  <= len_nxt;
        acc_r  <= acc_nxt;
      end
    end
  end

endmodule

// ===== rtl/ulm_accum.sv =====
// Saturating string counters, prefix cut search and the result register.
module ulm_accum #(
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  ulm_pkg::in_item_t   item,
  input  ulm_pkg::char_info_t info,
  input  logic                out_stall,
  output logic                out_valid,
  output ulm_pkg::out_item_t  out_item
);
  import ulm_pkg::*;

  localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [COUNT_BITS-1:0] u16_r, u16_nxt;
  logic [COUNT_BITS-1:0] kept_r, kept_nxt;
  logic [COUNT_BITS-1:0] full_r, full_nxt;
  logic [COUNT_BITS-1:0] prefix_r, prefix_nxt;
  logic [COUNT_BITS-1:0] cut_r, cut_nxt;
  logic                  stopped_r, stopped_nxt;
  logic                  out_valid_r;
  out_item_t             out_item_r;

  logic [CW-1:0] start_w, rs_w, re_w, budget_w, kept_w, cut_w, u16_w, full_w;
  logic [CW:0]   prefix_sum;
  logic          excluded, fits;

  function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                    input logic [2:0] b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + (COUNT_BITS+1)'(b);
    return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
  endfunction

  always_comb begin
    start_w    = CW'(u16_r);
    rs_w       = CW'(item.remove_start);
    re_w       = CW'(item.remove_end);
    budget_w   = CW'(item.keep_budget);
    excluded   = (item.remove_end > item.remove_start) && (start_w >= rs_w) && (start_w < re_w);
    prefix_sum = (CW+1)'(prefix_r) + (CW+1)'(info.measure);
    fits       = !stopped_r && (prefix_sum <= {1'b0, budget_w});

    u16_nxt     = u16_r;
    kept_nxt    = kept_r;
    full_nxt    = full_r;
    prefix_nxt  = prefix_r;
    cut_nxt     = cut_r;
    stopped_nxt = stopped_r;
    if (info.fin) begin
      full_nxt = sat_add(full_r, info.measure);
      if (!excluded) kept_nxt = sat_add(kept_r, info.measure);
      if (fits) begin
        prefix_nxt = sat_add(prefix_r, info.measure);
        cut_nxt    = sat_add(cut_r, info.received);
      end else begin
        stopped_nxt = 1'b1;
      end
      u16_nxt = sat_add(u16_r, {1'b0, info.units});
    end
    kept_w = CW'(kept_nxt);
    cut_w  = CW'(cut_nxt);
    u16_w  = CW'(u16_nxt);
    full_w = CW'(full_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u16_r       <= '0;
      kept_r      <= '0;
      full_r      <= '0;
      prefix_r    <= '0;
      cut_r       <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step && item.last_byte) begin
        u16_r       <= '0;
        kept_r      <= '0;
        full_r      <= '0;
        prefix_r    <= '0;
        cut_r       <= '0;
        stopped_r   <= 1'b0;
        out_valid_r <= 1'b1;
      end else begin
        if (step) begin
          u16_r     <= u16_nxt;
          kept_r    <= kept_nxt;
          full_r    <= full_nxt;
          prefix_r  <= prefix_nxt;
          cut_r     <= cut_nxt;
          stopped_r <= stopped_nxt;
        end
        if (!out_stall) out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && item.last_byte) begin
      out_item_r.measured_length <= kept_w[15:0];
      out_item_r.cut_index       <= cut_w[15:0];
      out_item_r.over_budget     <= full_w > budget_w;
      out_item_r.utf16_units     <= u16_w[15:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/ulm_checker.sv =====
// Port-level checker for the UTF-8 length-limit measure block and its bind.
module ulm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input ulm_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input ulm_pkg::out_item_t out_item
);
  import ulm_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("stalled result changed");

  // Input backs up only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result slot");

  // A stalled input item stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input item changed");

  // Every string holds at least one character.
  a_units_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.utf16_units != 16'd0)
    else $error("result with no UTF-16 units");

endmodule

bind utf8_length_limit_measure ulm_checker u_ulm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ===== bench/tb_utf8_length_limit_measure.sv =====
// Self-checking testbench for the UTF-8 length-limit measure block.
`timescale 1ns / 1ps

module tb_utf8_length_limit_measure;
  import ulm_pkg::*;

  localparam int          COUNT_BITS  = 16;
  localparam int unsigned COUNT_MAX   = (1 << COUNT_BITS) - 1;
  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam int          RANDOM_ITEMS = 950;
  // Two-bit register value that no mode decodes: every character measures 0.
  localparam logic [1:0]  MODE_UNDEF  = 2'd3;
  // Cycles to let pass after the last result before touching the register.
  localparam int          SETTLE_CYCLES = 4;

  // Character mix for string generation.
  typedef enum int {SHAPE_MIX, SHAPE_TWO, SHAPE_FOUR} shape_e;

  // One row of the directed table; the expected result is used only when typed is set.
  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  text_byte;
    logic        last_byte;
    logic [15:0] remove_start;
    logic [15:0] remove_end;
    logic [15:0] keep_budget;
    logic        typed;
    logic [15:0] measured_length;
    logic [15:0] cut_index;
    logic        over_budget;
    logic [15:0] utf16_units;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_item;
  logic       cfg_wr_en;
  logic [1:0] cfg_wr_data;

  // Expected results, oldest first.
  out_item_t pending_measures [$];
  int        mismatches;
  int        cycle_count;
  int        quiet_items;    // items left in a no-gap stretch on the sender side
  int        hold_request;   // long receiver hold-off, picked up by the receiver process

  // Shadow of the block: register and per-string counters.
  logic [1:0]  mode_reg;
  int unsigned char_left;
  int unsigned char_len;
  logic [20:0] code_point;
  int unsigned u16_pos;
  int unsigned byte_pos;
  int unsigned kept_len;
  int unsigned full_len;
  int unsigned prefix_len;
  int unsigned cut_pos;
  bit          cut_done;

  // Directed strings: after reset, extremes, each mode, stray and truncated characters.
  dir_row_t stim_table [25] = '{
    // single NUL with zero budget: nothing fits, whole string over budget
    '{MODE_BYTES, 8'h00, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'd1, 16'd0, 1'b1, 16'd1},
    // 0xFF alone: stray lead of a 4-byte character, truncated after one byte
    '{MODE_BYTES, 8'hFF, 1'b1, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 16'd1, 16'd1, 1'b0, 16'd2},
    // only character sits in the removed range
    '{MODE_BYTES, 8'h7F, 1'b1, 16'h0000, 16'h0001, 16'h0001, 1'b1, 16'd0, 16'd1, 1'b0, 16'd1},
    '{MODE_BYTES, 8'hC3, 1'b0, 16'h0000, 16'h0000, 16'h0001, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{MODE_BYTES, 8'hA9, 1'b1, 16'h0000, 16'h0000, 16'h0001, 1'b1, 16'd2, 16'd0, 1'b1, 16'd1},
    // U+1F600 counted as one character, two UTF-16 units; start above end means no removal
    '{MODE_CHARS, 8'hF0, 1'b0, 16'hFFFF, 16'h0000, 16'h0001, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{MODE_CHARS, 8'h9F, 1'b0, 16'hFFFF, 16'h0000, 16'h0001, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{MODE_CHARS, 8'h98, 1'b0, 16'hFFFF, 16'h0000, 16'h0001, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{MODE_CHARS, 8'h80, 1'b1, 16'hFFFF, 16'h0000, 16'h0001, 1'b1, 16'd1, 16'd4, 1'b0, 16'd2},
    // U+200B, U+FEFF, U+200E, 'A': widths 1,1,2,1; middle two removed; cut stops at U+200E
    '{MODE_WIDTH, 8'hE2, 1'b0, 16'h0001, 16'h0003, 16'h0002, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{MODE_WIDTH, 8'h80, 1'b0, 16'h0001, 16'h0003, 16'h0002, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{MODE_WIDTH, 8'h8B, 1'b0, 16'h0001, 16'h0003, 16'h0002, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{MODE_WIDTH, 8'hEF, 1'b0, 16'h0001, 16'h0003, 16'h0002, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{MODE_WIDTH, 8'hBB, 1'b0, 16'h0001, 16'h0003, 16'h0002, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{MODE_WIDTH, 8'hBF, 1'b0, 16'h0001, 16'h0003, 16'h0002, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{MODE_WIDTH, 8'hE2, 1'b0, 16'h0001, 16'h0003, 16'h0002, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{MODE_WIDTH, 8'h80, 1'b0, 16'h0001, 16'h0003, 16'h0002, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{MODE_WIDTH, 8'h8E, 1'b0, 16'h0001, 16'h0003, 16'h0002, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{MODE_WIDTH, 8'h41, 1'b1, 16'h0001, 16'h0003, 16'h0002, 1'b1, 16'd2, 16'd6, 1'b1, 16'd4},
    // 3-byte character cut off after two bytes: width 2, still enters the prefix
    '{MODE_WIDTH, 8'hE2, 1'b0, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{MODE_WIDTH, 8'h80, 1'b1, 16'h0000, 16'h0000, 16'hFFFF, 1'b1, 16'd2, 16'd2, 1'b0, 16'd1},
    // undecoded mode: everything measures 0, the cut covers the whole string
    '{MODE_UNDEF, 8'h41, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{MODE_UNDEF, 8'hC3, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'd0, 16'd2, 1'b0, 16'd2},
    // continuation byte in lead position starts a 4-byte character, truncated and removed
    '{MODE_BYTES, 8'h80, 1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0},
    '{MODE_BYTES, 8'hBF, 1'b1, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 16'd0, 16'd2, 1'b0, 16'd2}
  };

  utf8_length_limit_measure #(
    .COUNT_BITS(COUNT_BITS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow model
  // ---------------------------------------------------------------------------

  function automatic int unsigned sat_count(input int unsigned a, input int unsigned b);
    int unsigned s;
    s = a + b;
    return (s > COUNT_MAX) ? COUNT_MAX : s;
  endfunction

  // The zero-width characters U+200B to U+200D and the byte-order mark count as narrow; so does ASCII.
  function automatic int unsigned glyph_width(input logic [20:0] cp);
    if (cp < ASCII_LIMIT) return 1;
    if (cp >= ZW_FIRST && cp <= ZW_LAST) return 1;
    if (cp == BOM_CP) return 1;
    return 2;
  endfunction

  function automatic void clear_string_state();
    char_left  = 0;
    char_len   = 0;
    code_point = '0;
    u16_pos    = 0;
    byte_pos   = 0;
    kept_len   = 0;
    full_len   = 0;
    prefix_len = 0;
    cut_pos    = 0;
    cut_done   = 1'b0;
  endfunction

  // Fold one finished (or truncated) character into the string counters.
  function automatic void close_char(input logic [15:0] rs, input logic [15:0] re,
                                     input logic [15:0] budget);
    int unsigned got;
    int unsigned m;
    bit          partial;
    bit          removed;
    got     = char_len - char_left;
    partial = (char_left != 0);
    removed = (re > rs) && (u16_pos >= rs) && (u16_pos < re);
    case (mode_reg)
      MODE_BYTES: m = got;
      MODE_CHARS: m = 1;
      MODE_WIDTH: m = partial ? 2 : glyph_width(code_point);
      default:    m = 0;
    endcase
    full_len = sat_count(full_len, m);
    if (!removed) kept_len = sat_count(kept_len, m);
    // once one character misses the budget, the prefix is frozen
    if (!cut_done && (prefix_len + m <= budget)) begin
      prefix_len = sat_count(prefix_len, m);
      cut_pos    = sat_count(cut_pos, got);
    end else begin
      cut_done = 1'b1;
    end
    u16_pos    = sat_count(u16_pos, (char_len == 4) ? 2 : 1);
    char_left  = 0;
    char_len   = 0;
    code_point = '0;
  endfunction

  // Advance the shadow by one accepted byte; returns 1 with the result on the last byte.
  function automatic bit measure_byte(input in_item_t it, output out_item_t res);
    logic [7:0] b;
    b   = it.text_byte;
    res = '0;
    if (char_left == 0) begin
      casez (b)
        8'b0???????: begin char_len = 1; code_point = {14'd0, b[6:0]}; end
        8'b110?????: begin char_len = 2; code_point = {16'd0, b[4:0]}; end
        8'b1110????: begin char_len = 3; code_point = {17'd0, b[3:0]}; end
        default:     begin char_len = 4; code_point = {18'd0, b[2:0]}; end
      endcase
      char_left = char_len - 1;
    end else begin
      // any byte in a following position is taken as a continuation
      code_point = {code_point[14:0], b[5:0]};
      char_left  = char_left - 1;
    end
    byte_pos = sat_count(byte_pos, 1);
    if (char_left == 0 || it.last_byte)
      close_char(it.remove_start, it.remove_end, it.keep_budget);
    if (!it.last_byte) return 1'b0;
    res.measured_length = kept_len[15:0];
    res.cut_index       = cut_pos[15:0];
    res.over_budget     = (full_len > it.keep_budget);
    res.utf16_units     = u16_pos[15:0];
    clear_string_state();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly no gap, some short gaps, a few long ones, and now and then a gap-free run.
  function automatic int pick_gap();
    int r;
    if (quiet_items > 0) begin
      quiet_items--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_items = $urandom_range(20, 80);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one item, hold it until accepted, then record what it should produce.
  task automatic send_item(input in_item_t it, input bit burst, input bit typed,
                           input out_item_t typed_res);
    int        gap;
    out_item_t res;
    @(negedge clk);
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (measure_byte(it, res))
      pending_measures.push_back(typed ? typed_res : res);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle.
  task automatic wait_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_measures.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] mode);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    mode_reg = mode;
  endtask

  // Mostly small operands so removal and budget cuts land inside short strings.
  function automatic void pick_operands(output logic [15:0] rs, output logic [15:0] re,
                                        output logic [15:0] budget);
    if ($urandom_range(0, 6) == 0) begin
      rs     = 16'($urandom);
      re     = 16'($urandom);
      budget = 16'($urandom);
    end else begin
      rs     = 16'($urandom_range(0, 10));
      re     = 16'($urandom_range(0, 14));
      budget = 16'($urandom_range(0, 24));
    end
  endfunction

  // Append one character; the mix includes the narrow specials, their neighbors and noise.
  function automatic void append_char(ref logic [7:0] text [$], input shape_e shape);
    int          pick;
    logic [20:0] cp;
    case (shape)
      SHAPE_TWO:  pick = 40;
      SHAPE_FOUR: pick = 80;
      default:    pick = $urandom_range(0, 99);
    endcase
    if (pick < 30) begin
      text.push_back({1'b0, 7'($urandom)});
    end else if (pick < 45) begin
      text.push_back({3'b110, 5'($urandom)});
      text.push_back({2'b10, 6'($urandom)});
    end else if (pick < 65) begin
      case ($urandom_range(0, 9))
        0:       cp = ZW_FIRST;
        1:       cp = ZW_FIRST + 21'd1;
        2:       cp = ZW_LAST;
        3:       cp = BOM_CP;
        4:       cp = ZW_FIRST - 21'd1;
        5:       cp = ZW_LAST + 21'd1;
        6:       cp = BOM_CP - 21'd1;
        7:       cp = BOM_CP + 21'd1;
        default: cp = 21'($urandom_range(0, 16'hFFFF));
      endcase
      text.push_back({4'b1110, cp[15:12]});
      text.push_back({2'b10, cp[11:6]});
      text.push_back({2'b10, cp[5:0]});
    end else if (pick < 85) begin
      text.push_back({5'b11110, 3'($urandom)});
      repeat (3) text.push_back({2'b10, 6'($urandom)});
    end else begin
      text.push_back(8'($urandom));
    end
  endfunction

  // Send a string of nbytes bytes; a character split by the end stays truncated.
  // With drift set, the operands change on every byte after the first.
  task automatic send_string(input int nbytes, input shape_e shape, input bit burst,
                             input logic [15:0] rs, input logic [15:0] re,
                             input logic [15:0] budget, input bit drift);
    logic [7:0] text [$];
    logic [15:0] s, e, bud;
    in_item_t   it;
    out_item_t  unused;
    unused = '0;
    s   = rs;
    e   = re;
    bud = budget;
    while (text.size() < nbytes) append_char(text, shape);
    while (text.size() > nbytes) void'(text.pop_back());
    for (int k = 0; k < nbytes; k++) begin
      if (drift && k > 0) pick_operands(s, e, bud);
      it.text_byte    = text[k];
      it.last_byte    = (k == nbytes - 1);
      it.remove_start = s;
      it.remove_end   = e;
      it.keep_budget  = bud;
      send_item(it, burst, 1'b0, unused);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall runs, plus one long hold-off on request
  // ---------------------------------------------------------------------------

  int rx_run;
  bit rx_hold;

  always @(negedge clk) begin : receiver
    int r;
    if (hold_request != 0) begin
      rx_run       = hold_request;
      rx_hold      = 1'b1;
      hold_request = 0;
    end else if (rx_run <= 0) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        rx_hold = 1'b0;
        rx_run  = $urandom_range(1, 30);
      end else if (r < 93) begin
        rx_hold = 1'b1;
        rx_run  = $urandom_range(1, 3);
      end else begin
        rx_hold = 1'b1;
        rx_run  = $urandom_range(15, 60);
      end
    end
    out_stall <= rx_hold;
    rx_run = rx_run - 1;
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_measures.size() == 0) begin
        $error("unexpected result: measured_length %0d cut_index %0d over_budget %0d %s %0d",
               out_item.measured_length, out_item.cut_index, out_item.over_budget,
               "utf16_units", out_item.utf16_units);
        mismatches++;
      end else begin
        want = pending_measures.pop_front();
        if (out_item.measured_length !== want.measured_length) begin
          $error("measured_length: expected %0d, got %0d",
                 want.measured_length, out_item.measured_length);
          mismatches++;
        end
        if (out_item.cut_index !== want.cut_index) begin
          $error("cut_index: expected %0d, got %0d", want.cut_index, out_item.cut_index);
          mismatches++;
        end
        if (out_item.over_budget !== want.over_budget) begin
          $error("over_budget: expected %0d, got %0d", want.over_budget, out_item.over_budget);
          mismatches++;
        end
        if (out_item.utf16_units !== want.utf16_units) begin
          $error("utf16_units: expected %0d, got %0d", want.utf16_units, out_item.utf16_units);
          mismatches++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    dir_row_t    row;
    in_item_t    it;
    out_item_t   want;
    logic [15:0] rs, re, budget;
    int          sent;
    int          strings;
    int          len;

    clk          = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    out_stall    = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = MODE_BYTES;
    mismatches   = 0;
    cycle_count  = 0;
    quiet_items  = 0;
    hold_request = 0;
    rx_run       = 0;
    rx_hold      = 1'b0;
    mode_reg     = MODE_BYTES;
    clear_string_state();

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table. The first rows run on the register's reset value, which is
    // byte mode; a mode change only ever falls between two strings.
    foreach (stim_table[r]) begin
      row = stim_table[r];
      if (row.mode != mode_reg) begin
        wait_quiet();
        write_mode(row.mode);
      end
      it.text_byte    = row.text_byte;
      it.last_byte    = row.last_byte;
      it.remove_start = row.remove_start;
      it.remove_end   = row.remove_end;
      it.keep_budget  = row.keep_budget;
      want.measured_length = row.measured_length;
      want.cut_index       = row.cut_index;
      want.over_budget     = row.over_budget;
      want.utf16_units     = row.utf16_units;
      send_item(it, 1'b0, row.typed, want);
    end

    // Longer strings of wide characters sent back to back. In byte mode with
    // 4-byte characters the removed range sits at the very top of the UTF-16
    // index space and catches nothing.
    wait_quiet();
    write_mode(MODE_BYTES);
    send_string(160, SHAPE_FOUR, 1'b1, 16'hFFFE, 16'hFFFF, 16'hFFFF, 1'b0);
    // Character mode with 2-byte characters, every one inside the removed range.
    wait_quiet();
    write_mode(MODE_CHARS);
    send_string(100, SHAPE_TWO, 1'b1, 16'h0000, 16'h0064, 16'hFFFF, 1'b0);

    // Random strings, mostly short and well formed, with noise bytes and
    // truncated endings mixed in; the mode is rewritten every few strings.
    sent    = 0;
    strings = 0;
    while (sent < RANDOM_ITEMS) begin
      if (strings % 15 == 0) begin
        wait_quiet();
        write_mode(2'($urandom_range(0, 3)));
      end
      if (strings == 40) begin
        // Hold the receiver off for a long stretch while short strings keep
        // coming, so results back up and the input stalls; then drain fully.
        hold_request = 400;
        repeat (30) begin
          pick_operands(rs, re, budget);
          len = $urandom_range(1, 4);
          send_string(len, SHAPE_MIX, 1'b1, rs, re, budget, 1'b0);
          sent += len;
        end
        wait_quiet();
      end
      pick_operands(rs, re, budget);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      send_string(len, SHAPE_MIX, 1'b0, rs, re, budget, $urandom_range(0, 9) == 0);
      sent += len;
      strings++;
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== utf8_length_limit_measure.f =====
rtl/ulm_pkg.sv
rtl/ulm_decode.sv
rtl/ulm_accum.sv
rtl/utf8_length_limit_measure.sv
rtl/ulm_checker.sv
bench/tb_utf8_length_limit_measure.sv
